### src/hsl_to_rgb_converter_assert.svh
// ----------------------------------------------------------------------------
// HSL to RGB converter assertion macros
// Concurrent assertion shorthands shared by the converter RTL.
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH

// Same-cycle implication, masked while rst is high.
`define HSL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsl_to_rgb_converter: same-cycle check failed");

// Next-cycle implication, masked while rst is high.
`define HSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hsl_to_rgb_converter: next-cycle check failed");

`endif

### src/hsl2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter package
// Shared constants and types for the converter and its channel interfaces.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

   // Default number of fraction bits of hue, saturation and lightness.
   localparam int FRACTION_BITS_DEFAULT = 16;

   // Width of one output color channel.
   localparam int CHAN_BITS = 8;

   typedef logic [2:0] sextant_type;

   // Hue sextants; codes above the magenta-to-red sextant never occur.
   localparam sextant_type HUE_RED_YELLOW   = 3'd0;
   localparam sextant_type HUE_YELLOW_GREEN = 3'd1;
   localparam sextant_type HUE_GREEN_CYAN   = 3'd2;
   localparam sextant_type HUE_CYAN_BLUE    = 3'd3;
   localparam sextant_type HUE_BLUE_MAGENTA = 3'd4;
   localparam sextant_type HUE_MAGENTA_RED  = 3'd5;

endpackage

### src/hsl2rgb_if.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter channel interfaces
// Valid/ready channels for the HSL pixel input and the RGB pixel output.
// ----------------------------------------------------------------------------
interface hsl2rgb_req_if #(
   parameter int FRACTION_BITS = hsl2rgb_pkg::FRACTION_BITS_DEFAULT
);
   logic                     valid;
   logic                     ready;
   logic [FRACTION_BITS-1:0] hue;
   logic [FRACTION_BITS:0]   saturation;
   logic [FRACTION_BITS:0]   lightness;

   modport source (output valid, output hue, output saturation, output lightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input lightness,
                   output ready);
endinterface

interface hsl2rgb_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [hsl2rgb_pkg::CHAN_BITS-1:0] red;
   logic [hsl2rgb_pkg::CHAN_BITS-1:0] green;
   logic [hsl2rgb_pkg::CHAN_BITS-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### src/hsl_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter
// Five-stage pipeline turning an HSL pixel into 8-bit red, green and blue.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one pixel per item: hue as a fraction of a full turn,
//   saturation and lightness as fractions that may reach exactly 1.0 (larger
//   codes clamp to 1.0). rsp_if returns one item per pixel with red, green and
//   blue, each the channel fraction times 255, truncated.
//   Timing: an item accepted on req_if passes through five register stages,
//   the last one being the output register, before it is offered on rsp_if.
//   Throughput: one item per cycle, set by the two multiplier
//   stages (lightness times saturation, then chroma span times hue fraction),
//   each of which takes a new operand pair every cycle.
//   Stalls: each stage holds its item while the stage after it is full and
//   not moving; req_if.ready drops only once every stage is occupied and the
//   receiver holds rsp_if.ready low. Nothing is dropped or repeated.
//   Reset: synchronous, clears all stage valid bits; the pipeline comes out
//   of reset empty and ready. There is no other state.
// ----------------------------------------------------------------------------
`include "hsl_to_rgb_converter_assert.svh"

module hsl_to_rgb_converter #(
   parameter int FRACTION_BITS = hsl2rgb_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   hsl2rgb_req_if.sink          req_if,
   hsl2rgb_rsp_if.source        rsp_if
);

   localparam int F  = FRACTION_BITS;
   localparam int W  = F + 1;          // saturation / lightness width
   localparam int VW = 2 * F + 1;      // channel values with 2F fraction bits
   localparam int CB = hsl2rgb_pkg::CHAN_BITS;

   localparam logic [W-1:0] ONE_W  = {1'b1, {F{1'b0}}};
   localparam logic [W-1:0] HALF_W = ONE_W >> 1;
   // full-scale channel value, 1.0 with 2F fraction bits
   localparam logic [VW-1:0] CHAN_FULL = {ONE_W, {F{1'b0}}};

   // ------------------------------------------------------------------------
   // Stage handshake: a stage may load when it is empty or its item moves on
   // ------------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy;

   assign s5_rdy = !s5_valid_ff || rsp_if.ready;
   assign s4_rdy = !s4_valid_ff || s5_rdy;
   assign s3_rdy = !s3_valid_ff || s4_rdy;
   assign s2_rdy = !s2_valid_ff || s3_rdy;
   assign s1_rdy = !s1_valid_ff || s2_rdy;

   assign req_if.ready = s1_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (s1_rdy) s1_valid_ff <= req_if.valid;
         if (s2_rdy) s2_valid_ff <= s1_valid_ff;
         if (s3_rdy) s3_valid_ff <= s2_valid_ff;
         if (s4_rdy) s4_valid_ff <= s3_valid_ff;
         if (s5_rdy) s5_valid_ff <= s4_valid_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: clamp, lightness times saturation, hue sextant and fraction
   // ------------------------------------------------------------------------
   logic [W-1:0]                  sat_in, lit_in;
   logic [VW-1:0]                 prod_in;
   logic [F+2:0]                  hue6_in;
   logic [W-1:0]                  s1_sat_ff, s1_lit_ff;
   logic [VW-1:0]                 s1_prod_ff;
   logic                          s1_low_ff;
   hsl2rgb_pkg::sextant_type      s1_sext_ff;
   logic [F-1:0]                  s1_fract_ff;

   always_comb begin
      sat_in  = (req_if.saturation > ONE_W) ? ONE_W : req_if.saturation;
      lit_in  = (req_if.lightness  > ONE_W) ? ONE_W : req_if.lightness;
      // product is at most 1.0 with 2F fraction bits, so VW bits hold it
      prod_in = {{F{1'b0}}, lit_in} * {{F{1'b0}}, sat_in};
      // hue * 6 as hue*4 + hue*2
      hue6_in = {1'b0, req_if.hue, 2'b00} + {2'b00, req_if.hue, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (s1_rdy && req_if.valid) begin
         s1_sat_ff   <= sat_in;
         s1_lit_ff   <= lit_in;
         s1_prod_ff  <= prod_in;
         s1_low_ff   <= (lit_in <= HALF_W);
         s1_sext_ff  <= hue6_in[F+2:F];
         s1_fract_ff <= hue6_in[F-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: chroma top v, bottom m = 2l - v, span d = v - m
   // ------------------------------------------------------------------------
   logic [VW:0]                   v_wide_in, m_wide_in;
   logic [VW-1:0]                 v_in, m_in;
   logic [W:0]                    lps_in;
   logic [VW-1:0]                 s2_v_ff, s2_m_ff, s2_d_ff;
   logic                          s2_gray_ff;
   logic [W-1:0]                  s2_lit_ff;
   hsl2rgb_pkg::sextant_type      s2_sext_ff;
   logic [F-1:0]                  s2_fract_ff;

   always_comb begin
      lps_in = {1'b0, s1_lit_ff} + {1'b0, s1_sat_ff};
      if (s1_low_ff) begin
         v_wide_in = {1'b0, s1_lit_ff, {F{1'b0}}} + {1'b0, s1_prod_ff};
      end else begin
         v_wide_in = {lps_in, {F{1'b0}}} - {1'b0, s1_prod_ff};
      end
      v_in      = v_wide_in[VW-1:0];
      m_wide_in = {s1_lit_ff, {(F + 1){1'b0}}} - v_wide_in;
      m_in      = m_wide_in[VW-1:0];
   end

   always_ff @(posedge clock) begin
      if (s2_rdy && s1_valid_ff) begin
         s2_v_ff     <= v_in;
         s2_m_ff     <= m_in;
         s2_d_ff     <= v_in - m_in;
         s2_gray_ff  <= (v_in == '0);
         s2_lit_ff   <= s1_lit_ff;
         s2_sext_ff  <= s1_sext_ff;
         s2_fract_ff <= s1_fract_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: span times hue fraction as two partial products
   // ------------------------------------------------------------------------
   logic [VW-1:0]                 s3_pp_hi_ff, s3_v_ff, s3_m_ff;
   logic [2*F-1:0]                s3_pp_lo_ff;
   logic                          s3_gray_ff;
   logic [W-1:0]                  s3_lit_ff;
   hsl2rgb_pkg::sextant_type      s3_sext_ff;

   always_ff @(posedge clock) begin
      if (s3_rdy && s2_valid_ff) begin
         s3_pp_hi_ff <= {{F{1'b0}}, s2_d_ff[VW-1:F]} * {{(F + 1){1'b0}}, s2_fract_ff};
         s3_pp_lo_ff <= {{F{1'b0}}, s2_d_ff[F-1:0]} * {{F{1'b0}}, s2_fract_ff};
         s3_v_ff     <= s2_v_ff;
         s3_m_ff     <= s2_m_ff;
         s3_gray_ff  <= s2_gray_ff;
         s3_lit_ff   <= s2_lit_ff;
         s3_sext_ff  <= s2_sext_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4: middle values and sextant mux
   // ------------------------------------------------------------------------
   logic [VW-1:0] vsf_in, mid1_in, mid2_in, gray_in;
   logic [VW-1:0] red_in, green_in, blue_in;
   logic [VW-1:0] s4_red_ff, s4_green_ff, s4_blue_ff;

   always_comb begin
      vsf_in  = s3_pp_hi_ff + {{(F + 1){1'b0}}, s3_pp_lo_ff[2*F-1:F]};
      mid1_in = s3_m_ff + vsf_in;
      mid2_in = s3_v_ff - vsf_in;
      gray_in = {s3_lit_ff, {F{1'b0}}};
      case (s3_sext_ff)
         hsl2rgb_pkg::HUE_RED_YELLOW: begin
            red_in = s3_v_ff;  green_in = mid1_in; blue_in = s3_m_ff;
         end
         hsl2rgb_pkg::HUE_YELLOW_GREEN: begin
            red_in = mid2_in;  green_in = s3_v_ff; blue_in = s3_m_ff;
         end
         hsl2rgb_pkg::HUE_GREEN_CYAN: begin
            red_in = s3_m_ff;  green_in = s3_v_ff; blue_in = mid1_in;
         end
         hsl2rgb_pkg::HUE_CYAN_BLUE: begin
            red_in = s3_m_ff;  green_in = mid2_in; blue_in = s3_v_ff;
         end
         hsl2rgb_pkg::HUE_BLUE_MAGENTA: begin
            red_in = mid1_in;  green_in = s3_m_ff; blue_in = s3_v_ff;
         end
         default: begin
            red_in = s3_v_ff;  green_in = s3_m_ff; blue_in = mid2_in;
         end
      endcase
      // zero chroma top: gray at the lightness level
      if (s3_gray_ff) begin
         red_in   = gray_in;
         green_in = gray_in;
         blue_in  = gray_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_rdy && s3_valid_ff) begin
         s4_red_ff   <= red_in;
         s4_green_ff <= green_in;
         s4_blue_ff  <= blue_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 5: scale by 255 (shift and subtract), truncate, output register
   // ------------------------------------------------------------------------
   function automatic logic [CB-1:0] scale255(input logic [VW-1:0] c);
      logic [VW+CB-1:0] x;
      x = {c, {CB{1'b0}}} - {{CB{1'b0}}, c};
      return x[2*F+CB-1:2*F];
   endfunction

   logic [CB-1:0] s5_red_ff, s5_green_ff, s5_blue_ff;

   always_ff @(posedge clock) begin
      if (s5_rdy && s4_valid_ff) begin
         s5_red_ff   <= scale255(s4_red_ff);
         s5_green_ff <= scale255(s4_green_ff);
         s5_blue_ff  <= scale255(s4_blue_ff);
      end
   end

   assign rsp_if.valid = s5_valid_ff;
   assign rsp_if.red   = s5_red_ff;
   assign rsp_if.green = s5_green_ff;
   assign rsp_if.blue  = s5_blue_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `HSL_ASSERT_NOW(a_sextant_range, clock, reset, s1_valid_ff,
                   s1_sext_ff <= hsl2rgb_pkg::HUE_MAGENTA_RED)
   `HSL_ASSERT_NOW(a_bottom_below_top, clock, reset, s3_valid_ff, s3_m_ff <= s3_v_ff)
   `HSL_ASSERT_NOW(a_channels_in_range, clock, reset, s4_valid_ff,
                   (s4_red_ff <= CHAN_FULL) && (s4_green_ff <= CHAN_FULL)
                   && (s4_blue_ff <= CHAN_FULL))
   `HSL_ASSERT_NEXT(a_stage4_holds, clock, reset, s4_valid_ff && !s4_rdy,
                    s4_valid_ff && $stable(s4_red_ff) && $stable(s4_blue_ff))
   `HSL_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset,
                    !s1_valid_ff && !s3_valid_ff && !s5_valid_ff)

endmodule
